FILE: hdl/path_cost_balance_direction_top_defines.svh
// ----------------------------------------------------------------------------
// Path cost balance direction - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PATH_COST_BALANCE_DIRECTION_TOP_DEFINES_SVH
`define PATH_COST_BALANCE_DIRECTION_TOP_DEFINES_SVH

// Same-cycle implication
`define PCBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PCBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pcbd_pkg.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - package
// Fixed field widths, direction limits and the command/status words that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcbd_pkg;

   localparam int WORD_BITS = 32;   // cost and delta word width
   localparam int IDX_BITS  = 6;    // path_index field width
   localparam int DIR_BITS  = 34;   // direction field width

   localparam longint DIR_MAX = 64'sd8589934591;
   localparam longint DIR_MIN = -64'sd8589934592;

   // Controller to datapath
   typedef struct packed {
      logic load;       // take one cost word into the batch
      logic clear;      // return batch statistics to reset values
      logic div_start;  // launch the mean division
      logic rd;         // read the stored cost at the walk index
      logic put_dir;    // issue one direction word
      logic put_eq;     // issue the equilibrated word
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic spread_ok;  // spread within delta (or empty batch)
      logic div_done;   // mean is ready
      logic last_idx;   // walk index is the final stored path
      logic out_free;   // output register can take a word
   } sts_type;

endpackage

FILE: hdl/pcbd_div.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - mean divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pcbd_div #(
   parameter int DW = 39,   // dividend width
   parameter int VW = 7     // divisor width
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);

   localparam int KW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff;
   logic [KW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   rem_sh;
   logic          take;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      take   = (rem_sh >= {1'b0, dvs_ff});
      if (take) begin
         rem_in = VW'(rem_sh - {1'b0, dvs_ff});
      end else begin
         rem_in = rem_sh[VW-1:0];
      end
      quo_in = {quo_ff[DW-2:0], take};
   end

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= KW'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == KW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Operand and partial remainder registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: hdl/pcbd_dpath.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - datapath
// Cost store, running sum/min/max, delta register, mean divider, the
// direction walk accumulator and the output register.
// ----------------------------------------------------------------------------
module pcbd_dpath #(
   parameter int MAX_PATHS = 64,
   parameter int COST_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcbd_pkg::cmd_type                     cmd,
   output pcbd_pkg::sts_type                     sts,
   input  logic [pcbd_pkg::WORD_BITS-1:0]        req_cost,
   input  logic                                  csr_we,
   input  logic [pcbd_pkg::WORD_BITS-1:0]        csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [pcbd_pkg::IDX_BITS-1:0]         rsp_path_index,
   output logic signed [pcbd_pkg::DIR_BITS-1:0]  rsp_direction,
   output logic                                  rsp_equilibrated,
   output logic                                  rsp_overflow,
   output logic                                  rsp_run_end
);

   localparam int CW   = (COST_BITS < pcbd_pkg::WORD_BITS) ? COST_BITS : pcbd_pkg::WORD_BITS;
   localparam int CNTW = $clog2(MAX_PATHS + 1);
   localparam int IW   = $clog2(MAX_PATHS);
   localparam int SUMW = CW + CNTW;
   localparam int ACCW = (SUMW + 2 > pcbd_pkg::DIR_BITS + 1) ? SUMW + 2
                                                              : pcbd_pkg::DIR_BITS + 1;
   localparam logic signed [ACCW-1:0] DIR_HI = ACCW'(pcbd_pkg::DIR_MAX);
   localparam logic signed [ACCW-1:0] DIR_LO = ACCW'(pcbd_pkg::DIR_MIN);

   logic [CW-1:0]   cost_mem [MAX_PATHS];
   logic [CW-1:0]   cost_in;
   logic [CNTW-1:0] count_ff;
   logic [SUMW-1:0] sum_ff;
   logic [CW-1:0]   min_ff;
   logic [CW-1:0]   max_ff;
   logic            ovf_ff;
   logic            full;
   logic [pcbd_pkg::WORD_BITS-1:0] delta_ff;
   logic [SUMW-1:0] mean;
   logic            div_done;
   logic [IW-1:0]   idx_ff;
   logic [CW-1:0]   rd_data_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic signed [ACCW-1:0] dir_step;
   logic signed [ACCW-1:0] dir_raw;
   logic signed [ACCW-1:0] dir_sat;
   logic            last_idx;
   logic            out_free;
   logic            rsp_valid_ff;
   logic [pcbd_pkg::IDX_BITS-1:0]        idx_out_ff;
   logic signed [pcbd_pkg::DIR_BITS-1:0] dir_out_ff;
   logic            eq_out_ff;
   logic            ovf_out_ff;
   logic            end_out_ff;

   assign cost_in = req_cost[CW-1:0];
   assign full    = (count_ff == CNTW'(MAX_PATHS));

   // Delta register
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
      end else if (csr_we) begin
         delta_ff <= csr_wdata;
      end
   end

   // Store one cost word while there is room
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         cost_mem[count_ff[IW-1:0]] <= cost_in;
      end
      if (cmd.rd) begin
         rd_data_ff <= cost_mem[idx_ff];
      end
   end

   // Batch statistics: count, sum, min, max, overflow
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUMW'(cost_in);
            if (cost_in < min_ff) begin
               min_ff <= cost_in;
            end
            if (cost_in > max_ff) begin
               max_ff <= cost_in;
            end
         end
      end
   end

   // Mean = sum / count
   pcbd_div #(
      .DW (SUMW),
      .VW (CNTW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (mean),
      .done     (div_done)
   );

   // Walk index and running sum of issued directions
   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.put_dir) begin
         idx_ff <= idx_ff + 1'b1;
         acc_ff <= acc_ff + dir_step;
      end
   end

   // Direction: mean minus cost, or the balancing term on the final path
   always_comb begin
      dir_step = ACCW'(mean) - ACCW'(rd_data_ff);
      dir_raw  = last_idx ? -acc_ff : dir_step;
      if (dir_raw > DIR_HI) begin
         dir_sat = DIR_HI;
      end else if (dir_raw < DIR_LO) begin
         dir_sat = DIR_LO;
      end else begin
         dir_sat = dir_raw;
      end
   end

   assign last_idx = ((CNTW'(idx_ff) + 1'b1) == count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Output register: load a word, drop valid once it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put_dir || cmd.put_eq) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put_eq) begin
         idx_out_ff <= '0;
         dir_out_ff <= '0;
         eq_out_ff  <= 1'b1;
         ovf_out_ff <= ovf_ff;
         end_out_ff <= 1'b1;
      end else if (cmd.put_dir) begin
         idx_out_ff <= pcbd_pkg::IDX_BITS'(idx_ff);
         dir_out_ff <= dir_sat[pcbd_pkg::DIR_BITS-1:0];
         eq_out_ff  <= 1'b0;
         ovf_out_ff <= ovf_ff;
         end_out_ff <= last_idx;
      end
   end

   // Status to the controller
   assign sts.spread_ok = (count_ff == '0) ||
                          (pcbd_pkg::WORD_BITS'(max_ff - min_ff) <= delta_ff);
   assign sts.div_done  = div_done;
   assign sts.last_idx  = last_idx;
   assign sts.out_free  = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_path_index   = idx_out_ff;
   assign rsp_direction    = dir_out_ff;
   assign rsp_equilibrated = eq_out_ff;
   assign rsp_overflow     = ovf_out_ff;
   assign rsp_run_end      = end_out_ff;

endmodule

FILE: hdl/pcbd_ctrl.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - controller
// Sequences load, spread check, mean division and the direction walk.
// ----------------------------------------------------------------------------
module pcbd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_batch_end,
   output logic              req_ready,
   input  pcbd_pkg::sts_type sts,
   output pcbd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_DIV,
      ST_RD,
      ST_PUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept = req_valid && ready_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_batch_end) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sts.spread_ok) begin
               if (sts.out_free) begin
                  cmd.put_eq = 1'b1;
                  cmd.clear  = 1'b1;
                  state_in   = ST_LOAD;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (sts.out_free) begin
               cmd.put_dir = 1'b1;
               if (sts.last_idx) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_LOAD);
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: hdl/path_cost_balance_direction_top.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - top level
// Batch path-cost balancing: stats on load, then one equilibrated word or one direction per path.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one path cost word per handshake; req_batch_end marks the
//   final word of a batch. Cost words are taken one per cycle while loading.
//   csr_we/csr_wdata write the delta tolerance; write it only while idle.
//   rsp_* returns result words. If max minus min cost is within delta, one
//   word with rsp_equilibrated set closes the batch. Otherwise one word per
//   stored path follows, in load order, rsp_run_end set on the final one.
//   After the batch-end word the controller runs the spread check, then the
//   bit-serial divider for the mean (quotient min(COST_BITS, 32) +
//   clog2(MAX_PATHS+1) bits wide), then the direction walk, in which each
//   word waits for a registered read of the cost store.
//   req_ready stays low from the batch-end word until the last result word
//   is in the output register.
//   A stalled rsp_ready holds the output register and pauses the walk; the
//   next batch may start loading while the final word waits.
//   Reset (synchronous) clears the batch statistics, delta and valid flags.
//   Words beyond MAX_PATHS are dropped and flag rsp_overflow.
// ----------------------------------------------------------------------------
module path_cost_balance_direction_top #(
   parameter int MAX_PATHS = 64,
   parameter int COST_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pcbd_pkg::WORD_BITS-1:0]        req_cost,
   input  logic                                  req_batch_end,
   input  logic                                  csr_we,
   input  logic [pcbd_pkg::WORD_BITS-1:0]        csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pcbd_pkg::IDX_BITS-1:0]         rsp_path_index,
   output logic signed [pcbd_pkg::DIR_BITS-1:0]  rsp_direction,
   output logic                                  rsp_equilibrated,
   output logic                                  rsp_overflow,
   output logic                                  rsp_run_end
);

   pcbd_pkg::cmd_type cmd;
   pcbd_pkg::sts_type sts;

   // Sequencer
   pcbd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_batch_end (req_batch_end),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // Store, statistics, divider and output register
   pcbd_dpath #(
      .MAX_PATHS (MAX_PATHS),
      .COST_BITS (COST_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cost         (req_cost),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_path_index   (rsp_path_index),
      .rsp_direction    (rsp_direction),
      .rsp_equilibrated (rsp_equilibrated),
      .rsp_overflow     (rsp_overflow),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

FILE: hdl/pcbd_checker.sv
// ----------------------------------------------------------------------------
// Path cost balance direction - port checker
// Watches the top-level ports for result-word shape and input blocking.
// ----------------------------------------------------------------------------
`include "path_cost_balance_direction_top_defines.svh"

module pcbd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_batch_end,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [pcbd_pkg::IDX_BITS-1:0]         rsp_path_index,
   input logic signed [pcbd_pkg::DIR_BITS-1:0]  rsp_direction,
   input logic                                  rsp_equilibrated,
   input logic                                  rsp_run_end
);

   // Stalled result word holds
   `PCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_direction) && $stable(rsp_path_index) && $stable(rsp_run_end), "result word changed while stalled")

   // Equilibrated word closes the batch with zero index and direction
   `PCBD_ASSERT_NOW(a_eq_shape, clock, reset, rsp_valid && rsp_equilibrated, rsp_run_end && (rsp_direction == '0) && (rsp_path_index == '0), "malformed equilibrated word")

   // Batch-end word blocks further input
   `PCBD_ASSERT_NEXT(a_end_block, clock, reset, req_valid && req_ready && req_batch_end, !req_ready, "input taken after batch end")

   // Walk in progress blocks input
   `PCBD_ASSERT_NOW(a_walk_block, clock, reset, rsp_valid && rsp_ready && !rsp_run_end, !req_ready, "input taken during direction walk")

endmodule

bind path_cost_balance_direction_top pcbd_checker u_pcbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_batch_end    (req_batch_end),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_path_index   (rsp_path_index),
   .rsp_direction    (rsp_direction),
   .rsp_equilibrated (rsp_equilibrated),
   .rsp_run_end      (rsp_run_end)
);
